// ===== src/lqrbc_pkg.sv =====
// Shared constants and types for the balance controller.
// Field widths, register indexes and the integral limit; no dependencies.
package lqrbc_pkg;

    // Payload and configuration widths
    localparam int DATA_W     = 32;
    localparam int PERIOD_W   = 17;
    localparam int LEVEL_W    = 8;
    localparam int DRIVE_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Integral saturation in whole units and the bits it needs above the fraction
    localparam int INT_LIMIT  = 500;
    localparam int INT_HEAD_W = 10;

    // Reset value of the sample period register
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(66);

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Configuration register indexes
    localparam cfg_index_t REG_GAIN_ANGLE      = 3'd0;
    localparam cfg_index_t REG_GAIN_ANGLE_RATE = 3'd1;
    localparam cfg_index_t REG_GAIN_POSITION   = 3'd2;
    localparam cfg_index_t REG_GAIN_VELOCITY   = 3'd3;
    localparam cfg_index_t REG_GAIN_INTEGRAL   = 3'd4;
    localparam cfg_index_t REG_SAMPLE_PERIOD   = 3'd5;
    localparam cfg_index_t REG_MIN_DRIVE       = 3'd6;
    localparam cfg_index_t REG_MAX_DRIVE       = 3'd7;

endpackage

// ===== src/lqr_balance_controller.sv =====
// Balance controller: state feedback with integral action, one shared multiplier.
// A sample runs through 8 sequencer steps between input transfer and result valid.
// Samples do not overlap; the single multiplier runs six products per sample.
// in_stall is high while a sample is in work, and the last step holds while a
// previous result still waits in the output register.
// Reset clears the integral, the sequencer and the output valid; config regs take defaults.
module lqr_balance_controller #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lqrbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lqrbc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [lqrbc_pkg::DATA_W-1:0]   angle,
    input  logic signed [lqrbc_pkg::DATA_W-1:0]   angle_rate,
    input  logic signed [lqrbc_pkg::DATA_W-1:0]   position,
    input  logic signed [lqrbc_pkg::DATA_W-1:0]   velocity,
    input  logic                                  clear_integral,
    // Result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lqrbc_pkg::DRIVE_W-1:0]  drive,
    output logic                                  clamped
);

    localparam int DATA_W  = lqrbc_pkg::DATA_W;
    localparam int INT_W   = FRAC_BITS + lqrbc_pkg::INT_HEAD_W;
    localparam int MB_W    = ((INT_W > DATA_W + 1) ? INT_W : DATA_W + 1) + 1;
    localparam int FULL_W  = DATA_W + MB_W;
    localparam int P_W     = FULL_W - FRAC_BITS;
    localparam int ACC_W   = P_W + 4;

    localparam logic signed [ACC_W-1:0] ONE  = ACC_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ILIM = ACC_W'(lqrbc_pkg::INT_LIMIT) << FRAC_BITS;

    // Sequencer state codes
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Sequencer steps
    localparam logic [2:0] STEP_PERIOD    = 3'd0;
    localparam logic [2:0] STEP_INTEGRATE = 3'd1;
    localparam logic [2:0] STEP_RATE      = 3'd2;
    localparam logic [2:0] STEP_POSITION  = 3'd3;
    localparam logic [2:0] STEP_DEADZONE  = 3'd4;
    localparam logic [2:0] STEP_INTEGRAL  = 3'd5;
    localparam logic [2:0] STEP_CART_SUM  = 3'd6;
    localparam logic [2:0] STEP_FINISH    = 3'd7;

    // Configuration registers
    logic signed [DATA_W-1:0] gain_angle_reg, gain_angle_next;
    logic signed [DATA_W-1:0] gain_angle_rate_reg, gain_angle_rate_next;
    logic signed [DATA_W-1:0] gain_position_reg, gain_position_next;
    logic signed [DATA_W-1:0] gain_velocity_reg, gain_velocity_next;
    logic signed [DATA_W-1:0] gain_integral_reg, gain_integral_next;
    logic [lqrbc_pkg::PERIOD_W-1:0] sample_period_reg, sample_period_next;
    logic [lqrbc_pkg::LEVEL_W-1:0]  min_drive_reg, min_drive_next;
    logic [lqrbc_pkg::LEVEL_W-1:0]  max_drive_reg, max_drive_next;

    // Sequencer and state
    logic       state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic signed [INT_W-1:0] integral_reg, integral_next;

    // Sample holding registers
    logic signed [DATA_W-1:0] angle_reg, angle_next;
    logic signed [DATA_W-1:0] angle_rate_reg, angle_rate_next;
    logic signed [DATA_W-1:0] position_reg, position_next;
    logic signed [DATA_W-1:0] velocity_reg, velocity_next;

    // Datapath registers
    logic signed [P_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] ua_reg, ua_next;

    // Output register
    logic                                 out_valid_reg, out_valid_next;
    logic signed [lqrbc_pkg::DRIVE_W-1:0] drive_reg, drive_next;
    logic                                 clamped_reg, clamped_next;

    // Datapath intermediates
    logic                    in_xfer;
    logic                    out_free;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [FULL_W-1:0] mul_full;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  int_sum;
    logic signed [ACC_W-1:0]  ua_raw;
    logic signed [ACC_W-1:0]  min_scaled;
    logic signed [ACC_W-1:0]  lim_pos;
    logic signed [ACC_W-1:0]  total;
    logic signed [ACC_W-1:0]  total_sat;
    logic signed [ACC_W-1:0]  quot;
    logic                    over_lim;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    // Configuration register writes
    always_comb
    begin
        gain_angle_next      = gain_angle_reg;
        gain_angle_rate_next = gain_angle_rate_reg;
        gain_position_next   = gain_position_reg;
        gain_velocity_next   = gain_velocity_reg;
        gain_integral_next   = gain_integral_reg;
        sample_period_next   = sample_period_reg;
        min_drive_next       = min_drive_reg;
        max_drive_next       = max_drive_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lqrbc_pkg::REG_GAIN_ANGLE:      gain_angle_next      = cfg_data;
                lqrbc_pkg::REG_GAIN_ANGLE_RATE: gain_angle_rate_next = cfg_data;
                lqrbc_pkg::REG_GAIN_POSITION:   gain_position_next   = cfg_data;
                lqrbc_pkg::REG_GAIN_VELOCITY:   gain_velocity_next   = cfg_data;
                lqrbc_pkg::REG_GAIN_INTEGRAL:   gain_integral_next   = cfg_data;
                lqrbc_pkg::REG_SAMPLE_PERIOD:
                    sample_period_next = cfg_data[lqrbc_pkg::PERIOD_W-1:0];
                lqrbc_pkg::REG_MIN_DRIVE:
                    min_drive_next = cfg_data[lqrbc_pkg::LEVEL_W-1:0];
                lqrbc_pkg::REG_MAX_DRIVE:
                    max_drive_next = cfg_data[lqrbc_pkg::LEVEL_W-1:0];
            endcase
        end
    end

    // Select multiplier operands for the current step
    always_comb
    begin
        unique case (step_reg)
            STEP_PERIOD:
            begin
                mul_a = position_reg;
                mul_b = MB_W'(sample_period_reg);
            end
            STEP_INTEGRATE:
            begin
                mul_a = gain_angle_reg;
                mul_b = MB_W'(angle_reg);
            end
            STEP_RATE:
            begin
                mul_a = gain_angle_rate_reg;
                mul_b = MB_W'(angle_rate_reg);
            end
            STEP_POSITION:
            begin
                mul_a = gain_position_reg;
                mul_b = MB_W'(position_reg);
            end
            STEP_DEADZONE:
            begin
                mul_a = gain_velocity_reg;
                mul_b = MB_W'(velocity_reg);
            end
            STEP_INTEGRAL:
            begin
                mul_a = gain_integral_reg;
                mul_b = MB_W'(integral_reg);
            end
            STEP_CART_SUM, STEP_FINISH:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared multiplier, floored back to the fixed-point scale
    assign mul_full  = mul_a * mul_b;
    assign prod_next = P_W'(mul_full >>> FRAC_BITS);
    assign prod_ext  = ACC_W'(prod_reg);

    // Integral update with saturation
    assign int_sum = ACC_W'(integral_reg) + prod_ext;

    // Angle term dead zone and feed-forward
    assign ua_raw     = -acc_reg;
    assign min_scaled = ACC_W'({min_drive_reg, {FRAC_BITS{1'b0}}});

    // Final sum, clamp and truncation toward zero
    assign lim_pos  = ACC_W'({max_drive_reg, {FRAC_BITS{1'b0}}});
    assign total    = ua_reg - acc_reg;
    assign over_lim = (total > lim_pos) || (total < -lim_pos);

    always_comb
    begin
        priority if (total > lim_pos)
            total_sat = lim_pos;
        else if (total < -lim_pos)
            total_sat = -lim_pos;
        else
            total_sat = total;
    end

    always_comb
    begin
        quot = total_sat >>> FRAC_BITS;
        if (total_sat[ACC_W-1] && (total_sat[FRAC_BITS-1:0] != '0))
            quot = quot + ACC_W'(1);
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        integral_next   = integral_reg;
        acc_next        = acc_reg;
        ua_next         = ua_reg;
        angle_next      = angle_reg;
        angle_rate_next = angle_rate_reg;
        position_next   = position_reg;
        velocity_next   = velocity_reg;
        out_valid_next  = out_valid_reg && out_stall;
        drive_next      = drive_reg;
        clamped_next    = clamped_reg;

        if (in_xfer)
        begin
            // Capture the sample and start the sequence
            angle_next      = angle;
            angle_rate_next = angle_rate;
            position_next   = position;
            velocity_next   = velocity;
            if (clear_integral)
                integral_next = '0;
            state_next = ST_RUN;
            step_next  = STEP_PERIOD;
        end
        else if (state_reg == ST_RUN)
        begin
            step_next = step_reg + 3'd1;
            unique case (step_reg)
                STEP_PERIOD:
                begin
                end
                STEP_INTEGRATE:
                begin
                    priority if (int_sum > ILIM)
                        integral_next = INT_W'(ILIM);
                    else if (int_sum < -ILIM)
                        integral_next = INT_W'(-ILIM);
                    else
                        integral_next = INT_W'(int_sum);
                end
                STEP_RATE:
                    acc_next = prod_ext;
                STEP_POSITION:
                    acc_next = acc_reg + prod_ext;
                STEP_DEADZONE:
                begin
                    priority if (ua_raw > ONE)
                        ua_next = ua_raw + min_scaled;
                    else if (ua_raw < -ONE)
                        ua_next = ua_raw - min_scaled;
                    else
                        ua_next = '0;
                    acc_next = prod_ext;
                end
                STEP_INTEGRAL, STEP_CART_SUM:
                    acc_next = acc_reg + prod_ext;
                STEP_FINISH:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        drive_next     = lqrbc_pkg::DRIVE_W'(quot);
                        clamped_next   = over_lim;
                        state_next     = ST_IDLE;
                        step_next      = STEP_PERIOD;
                    end
                    else
                    begin
                        step_next = step_reg;
                    end
                end
            endcase
        end
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            step_reg            <= STEP_PERIOD;
            integral_reg        <= '0;
            out_valid_reg       <= 1'b0;
            gain_angle_reg      <= '0;
            gain_angle_rate_reg <= '0;
            gain_position_reg   <= '0;
            gain_velocity_reg   <= '0;
            gain_integral_reg   <= '0;
            sample_period_reg   <= lqrbc_pkg::PERIOD_RESET;
            min_drive_reg       <= '0;
            max_drive_reg       <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            step_reg            <= step_next;
            integral_reg        <= integral_next;
            out_valid_reg       <= out_valid_next;
            gain_angle_reg      <= gain_angle_next;
            gain_angle_rate_reg <= gain_angle_rate_next;
            gain_position_reg   <= gain_position_next;
            gain_velocity_reg   <= gain_velocity_next;
            gain_integral_reg   <= gain_integral_next;
            sample_period_reg   <= sample_period_next;
            min_drive_reg       <= min_drive_next;
            max_drive_reg       <= max_drive_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        angle_reg      <= angle_next;
        angle_rate_reg <= angle_rate_next;
        position_reg   <= position_next;
        velocity_reg   <= velocity_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        ua_reg         <= ua_next;
        drive_reg      <= drive_next;
        clamped_reg    <= clamped_next;
    end

    // A transfer starts the sequence, so the next cycle is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer did not go busy after an input transfer");

    // The stored integral never leaves its saturation band
    assert property (@(posedge clk) disable iff (!rst_n)
        (ACC_W'(integral_reg) <= ILIM) && (ACC_W'(integral_reg) >= -ILIM))
        else $error("position integral outside its limit");

    // A clamped result sits exactly at one of the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |->
            (drive == $signed({1'b0, max_drive_reg})) ||
            (drive == -$signed({1'b0, max_drive_reg})))
        else $error("clamped result not at the drive limit");

    // A new result is written only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive))
        else $error("pending result overwritten");

endmodule

// ===== verif/tb_lqr_balance_controller.sv =====
// Self-checking testbench for lqr_balance_controller: directed table, then random samples.
// Predicts drive results from its own copy of gains, period and position integral, or uses a typed-in result.
// Depends on lqrbc_pkg and the controller RTL only.
module tb_lqr_balance_controller;

    // Package widths, types and register indexes used here
    localparam int DATA_W     = lqrbc_pkg::DATA_W;
    localparam int DRIVE_W    = lqrbc_pkg::DRIVE_W;
    localparam int CFG_DATA_W = lqrbc_pkg::CFG_DATA_W;
    localparam int PERIOD_W   = lqrbc_pkg::PERIOD_W;
    localparam int LEVEL_W    = lqrbc_pkg::LEVEL_W;
    localparam int INT_LIMIT  = lqrbc_pkg::INT_LIMIT;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = lqrbc_pkg::PERIOD_RESET;

    typedef lqrbc_pkg::cfg_index_t cfg_index_t;

    localparam cfg_index_t REG_GAIN_ANGLE      = lqrbc_pkg::REG_GAIN_ANGLE;
    localparam cfg_index_t REG_GAIN_ANGLE_RATE = lqrbc_pkg::REG_GAIN_ANGLE_RATE;
    localparam cfg_index_t REG_GAIN_POSITION   = lqrbc_pkg::REG_GAIN_POSITION;
    localparam cfg_index_t REG_GAIN_VELOCITY   = lqrbc_pkg::REG_GAIN_VELOCITY;
    localparam cfg_index_t REG_GAIN_INTEGRAL   = lqrbc_pkg::REG_GAIN_INTEGRAL;
    localparam cfg_index_t REG_SAMPLE_PERIOD   = lqrbc_pkg::REG_SAMPLE_PERIOD;
    localparam cfg_index_t REG_MIN_DRIVE       = lqrbc_pkg::REG_MIN_DRIVE;
    localparam cfg_index_t REG_MAX_DRIVE       = lqrbc_pkg::REG_MAX_DRIVE;

    localparam int FRAC        = 16;
    localparam int LATENCY     = 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BLOCK_ITEMS = 100;

    typedef struct packed {
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] angle_rate;
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
        logic                     clear_integral;
    } sensor_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } drive_cmd_t;

    // Register write, predicted sample, or sample with its result typed in
    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        cfg_index_t              idx;
        logic [CFG_DATA_W-1:0]   data;
        sensor_t                 smp;
        drive_cmd_t              res;
    } row_t;

    localparam int NUM_DIR = 41;
    localparam row_t DIR_TAB [0:NUM_DIR-1] = '{
        // reset gains and zero clamp: extremes give nothing
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0,
          '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0}, '{9'sd0, 1'b0}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0,
          '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1}, '{9'sd0, 1'b0}},
        '{ROW_CFG, REG_GAIN_ANGLE, 32'hFFFF0000, '0, '0},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h000A0000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd0, 1'b1}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd0, 1'b0}},
        // open clamp: dead-zone edge and truncation toward zero
        '{ROW_CFG, REG_MAX_DRIVE, 32'd255, '0, '0},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h000A0000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd10, 1'b0}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd0, 1'b0}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'hFFFD8000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{-9'sd2, 1'b0}},
        // feed-forward on both signs
        '{ROW_CFG, REG_MIN_DRIVE, 32'd5, '0, '0},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h000A0000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd15, 1'b0}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'hFFF60000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{-9'sd15, 1'b0}},
        // total right at the limit, just past it, and at the angle extremes
        '{ROW_CFG, REG_MAX_DRIVE, 32'd20, '0, '0},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h000F0000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd20, 1'b0}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h00100000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd20, 1'b1}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd20, 1'b1}},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{-9'sd20, 1'b1}},
        '{ROW_CFG, REG_MIN_DRIVE, 32'd255, '0, '0},
        '{ROW_CFG, REG_MAX_DRIVE, 32'd255, '0, '0},
        '{ROW_TYPED, REG_GAIN_ANGLE, 32'h0, '{32'h00018000, 32'h0, 32'h0, 32'h0, 1'b0},
          '{9'sd255, 1'b1}},
        // extreme gains, period above one second, integral saturation
        '{ROW_CFG, REG_GAIN_ANGLE_RATE, 32'hFFFF8000, '0, '0},
        '{ROW_CFG, REG_GAIN_POSITION, 32'hFFFE0000, '0, '0},
        '{ROW_CFG, REG_GAIN_VELOCITY, 32'h7FFFFFFF, '0, '0},
        '{ROW_CFG, REG_GAIN_INTEGRAL, 32'h80000000, '0, '0},
        '{ROW_CFG, REG_SAMPLE_PERIOD, 32'h0001FFFF, '0, '0},
        '{ROW_CFG, REG_MIN_DRIVE, 32'd0, '0, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0, '{32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 1'b1}, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0, '{32'h0, 32'h0, 32'h80000000, 32'h0, 1'b0}, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0,
          '{32'h0, 32'h00030000, 32'h0, 32'hFFFF0001, 1'b0}, '0},
        // zero period freezes the integral
        '{ROW_CFG, REG_SAMPLE_PERIOD, 32'h0, '0, '0},
        '{ROW_CFG, REG_GAIN_VELOCITY, 32'h80000000, '0, '0},
        '{ROW_CFG, REG_GAIN_INTEGRAL, 32'h7FFFFFFF, '0, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0,
          '{32'h0, 32'h0, 32'h12345678, 32'h00000001, 1'b0}, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}, '0},
        // period of exactly one second, negative saturation
        '{ROW_CFG, REG_SAMPLE_PERIOD, 32'h00010000, '0, '0},
        '{ROW_CFG, REG_GAIN_POSITION, 32'h0, '0, '0},
        '{ROW_CFG, REG_GAIN_VELOCITY, 32'h0, '0, '0},
        '{ROW_CFG, REG_GAIN_INTEGRAL, 32'h00000100, '0, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0, '{32'h0, 32'h0, 32'hFE0C0000, 32'h0, 1'b1}, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0, '{32'h0, 32'h0, 32'hFFFF0000, 32'h0, 1'b0}, '0},
        '{ROW_SAMPLE, REG_GAIN_ANGLE, 32'h0,
          '{32'h80000000, 32'h7FFFFFFF, 32'h00001234, 32'h80000000, 1'b0}, '0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    cfg_index_t                    cfg_index = REG_GAIN_ANGLE;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [DATA_W-1:0]      angle = '0;
    logic signed [DATA_W-1:0]      angle_rate = '0;
    logic signed [DATA_W-1:0]      position = '0;
    logic signed [DATA_W-1:0]      velocity = '0;
    logic                          clear_integral = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [DRIVE_W-1:0]     drive;
    logic                          clamped;

    // Predictor copy of the registers and the integral
    longint k_angle = 0;
    longint k_rate = 0;
    longint k_position = 0;
    longint k_velocity = 0;
    longint k_integral = 0;
    longint k_period = longint'(PERIOD_RESET);
    longint k_min_drive = 0;
    longint k_max_drive = 0;
    longint pos_integral = 0;

    drive_cmd_t  expected_drive_q [$];
    int unsigned send_idle_pct = 20;
    int unsigned recv_stall_pct = 58;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    lqr_balance_controller #(.FRAC_BITS(FRAC)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .angle          (angle),
        .angle_rate     (angle_rate),
        .position       (position),
        .velocity       (velocity),
        .clear_integral (clear_integral),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .clamped        (clamped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact product floored back to the fraction width
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic void load_setting(input cfg_index_t idx, input logic [31:0] data);
        case (idx)
            REG_GAIN_ANGLE:      k_angle = longint'($signed(data));
            REG_GAIN_ANGLE_RATE: k_rate = longint'($signed(data));
            REG_GAIN_POSITION:   k_position = longint'($signed(data));
            REG_GAIN_VELOCITY:   k_velocity = longint'($signed(data));
            REG_GAIN_INTEGRAL:   k_integral = longint'($signed(data));
            REG_SAMPLE_PERIOD:   k_period = longint'(data[PERIOD_W-1:0]);
            REG_MIN_DRIVE:       k_min_drive = longint'(data[LEVEL_W-1:0]);
            REG_MAX_DRIVE:       k_max_drive = longint'(data[LEVEL_W-1:0]);
            default: ;
        endcase
    endfunction

    // Advance the integral and work out the drive for one sample
    function automatic drive_cmd_t balance_drive(input sensor_t s);
        longint one;
        longint ilim;
        longint ua;
        longint uc;
        longint u;
        longint lim;
        drive_cmd_t r;
        one = longint'(1) <<< FRAC;
        ilim = longint'(INT_LIMIT) * one;
        if (s.clear_integral)
            pos_integral = 0;
        pos_integral += fx_mul(s.position, k_period);
        if (pos_integral > ilim)
            pos_integral = ilim;
        if (pos_integral < -ilim)
            pos_integral = -ilim;

        // angle term with dead zone and feed-forward
        ua = -(fx_mul(k_angle, s.angle) + fx_mul(k_rate, s.angle_rate));
        if (ua > one)
            ua += k_min_drive * one;
        else if (ua < -one)
            ua -= k_min_drive * one;
        else
            ua = 0;

        uc = -(fx_mul(k_position, s.position) + fx_mul(k_velocity, s.velocity) +
               fx_mul(k_integral, pos_integral));
        u = ua + uc;
        lim = k_max_drive * one;
        r.clamped = 1'b0;
        if (u > lim)
        begin
            u = lim;
            r.clamped = 1'b1;
        end
        if (u < -lim)
        begin
            u = -lim;
            r.clamped = 1'b1;
        end
        r.drive = DRIVE_W'(u / one);
        return r;
    endfunction

    function automatic logic [31:0] rand_gain();
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = 32'h80000000;
            1:       v = 32'h7FFFFFFF;
            2:       v = 32'h0;
            3, 4:    v = $urandom;
            default: v = $urandom_range(32'h80000) - 32'h40000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_period();
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = 32'h0;
            1:       v = 32'h00010000;
            2:       v = 32'h0001FFFF;
            3:       v = $urandom_range(32'h1FFFF);
            default: v = $urandom_range(1, 6554);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_level();
        logic [31:0] v;
        case ($urandom_range(5))
            0:       v = 32'd0;
            1:       v = 32'd255;
            default: v = $urandom_range(1, 254);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_reading();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'h80000000;
            1:       v = 32'h7FFFFFFF;
            2, 3:    v = $urandom;
            default: v = $urandom_range(32'h100000) - 32'h80000;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Hold a register write until the port takes it; the caller drops cfg_valid
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_setting(idx, data);
    endtask

    // Idle at random, then hold the sample until it transfers
    task automatic send_sample(input sensor_t s, input bit typed, input drive_cmd_t typed_res);
        drive_cmd_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        angle          <= s.angle;
        angle_rate     <= s.angle_rate;
        position       <= s.position;
        velocity       <= s.velocity;
        clear_integral <= s.clear_integral;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = balance_drive(s);
        expected_drive_q.push_back(typed ? typed_res : pred);
    endtask

    // Stop sending and wait for every outstanding drive result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
    endtask

    // Compare each result transfer with the oldest expectation, and stall at random
    always @(posedge clk)
    begin
        drive_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drive_q.size() == 0)
                report_mismatch($sformatf("unexpected result drive %0d clamped %0b",
                                          drive, clamped));
            else
            begin
                want = expected_drive_q.pop_front();
                if (drive !== want.drive)
                    report_mismatch($sformatf("drive got %0d want %0d", drive, want.drive));
                if (clamped !== want.clamped)
                    report_mismatch($sformatf("clamped got %0b want %0b", clamped,
                                              want.clamped));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_lqr_balance_controller: errors");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        sensor_t s;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; register writes only once the block is idle
        for (int i = 0; i < NUM_DIR; i++)
        begin
            r = DIR_TAB[i];
            if (r.kind == ROW_CFG)
            begin
                if (i == 0 || DIR_TAB[i-1].kind != ROW_CFG)
                    wait_drained();
                write_reg(r.idx, r.data);
                if (i == NUM_DIR - 1 || DIR_TAB[i+1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end
            else
                send_sample(r.smp, r.kind == ROW_TYPED, r.res);
        end

        // Random blocks under three idle patterns, fresh settings per block
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 58 : 0;
            recv_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 20 : 0;
            for (int blk = 0; blk < 3; blk++)
            begin
                wait_drained();
                write_reg(REG_GAIN_ANGLE, rand_gain());
                write_reg(REG_GAIN_ANGLE_RATE, rand_gain());
                write_reg(REG_GAIN_POSITION, rand_gain());
                write_reg(REG_GAIN_VELOCITY, rand_gain());
                write_reg(REG_GAIN_INTEGRAL, rand_gain());
                write_reg(REG_SAMPLE_PERIOD, rand_period());
                write_reg(REG_MIN_DRIVE, rand_level());
                write_reg(REG_MAX_DRIVE, rand_level());
                cfg_valid <= 1'b0;
                for (int n = 0; n < BLOCK_ITEMS; n++)
                begin
                    // hold off mid-block until the pipeline is empty
                    if (n == BLOCK_ITEMS / 2)
                        wait_drained();
                    s.angle          = rand_reading();
                    s.angle_rate     = rand_reading();
                    s.position       = rand_reading();
                    s.velocity       = rand_reading();
                    s.clear_integral = ($urandom_range(15) == 0);
                    send_sample(s, 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("tb_lqr_balance_controller: clean");
        else
            $display("tb_lqr_balance_controller: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lqrbc_pkg.sv
src/lqr_balance_controller.sv
verif/tb_lqr_balance_controller.sv
